@@ hw/rtl/slbm_pkg.sv @@
// Shared types and constants for the serial loaded bank mapper.
package slbm_pkg;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MAP_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int UNITS_W  = 5;
    localparam int BANK_W   = 5;
    localparam int PRG_BANK_W = 4;

    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_CHR     = 2'd1;
    localparam logic [1:0] TGT_PRG_ROM = 2'd2;
    localparam logic [1:0] TGT_PRG_RAM = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_UNITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VERTICAL = 2'd2;

    localparam logic [4:0] CONTROL_RESET = 5'h0C;
    localparam logic [UNITS_W-1:0] UNITS_RESET = 5'd16;
    localparam logic [UNITS_W-1:0] UNITS_MAX   = 5'd16;

    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    localparam logic [1:0] REG_SEL_CONTROL  = 2'd0;
    localparam logic [1:0] REG_SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] REG_SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] REG_SEL_PRG      = 2'd3;

    localparam logic [2:0] SHIFT_LAST = 3'd4;
    localparam logic [1:0] MIRROR_VERTICAL_CODE = 2'd2;

    typedef struct packed {
        logic [1:0]       target;
        logic [MAP_W-1:0] mapped_address;
        logic             write_enable;
        logic             vertical_mirroring;
    } result_t;

endpackage

@@ hw/rtl/slbm_core.sv @@
// Mapper state, serial register loading and address translation.
module slbm_core
    import slbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  mode,
    input  logic [ADDR_W-1:0]     address,
    input  logic [DATA_W-1:0]     write_data,
    output result_t               result
);

    logic [UNITS_W-1:0]    units_reg, units_next;
    logic                  chr_ram_reg, chr_ram_next;
    logic [3:0]            shift_bits_reg, shift_bits_next;
    logic [2:0]            shift_count_reg, shift_count_next;
    logic [4:0]            control_reg, control_next;
    logic [BANK_W-1:0]     chr_low_reg, chr_low_next;
    logic [BANK_W-1:0]     chr_high_reg, chr_high_next;
    logic [PRG_BANK_W-1:0] prg_bank_reg, prg_bank_next;
    logic                  mirror_reg, mirror_next;

    logic [3:0] last_unit;
    logic [4:0] load_value;
    logic [MAP_W-1:0] chr_addr;
    logic [MAP_W-1:0] prg_addr;

    always_comb
    begin
        if (units_reg == '0)
        begin
            last_unit = 4'd0;
        end
        else if (units_reg > UNITS_MAX)
        begin
            last_unit = 4'd15;
        end
        else
        begin
            last_unit = 4'(units_reg - 5'd1);
        end
    end

    always_comb
    begin
        if (control_reg[4])
        begin
            if (!address[12])
            begin
                chr_addr = MAP_W'({chr_low_reg, address[11:0]});
            end
            else
            begin
                chr_addr = MAP_W'({chr_high_reg, address[11:0]});
            end
        end
        else
        begin
            chr_addr = MAP_W'({chr_low_reg[4:1], address[12:0]});
        end
    end

    always_comb
    begin
        case (control_reg[3:2])
            PRG_MODE_FIX_FIRST:
            begin
                if (!address[14])
                begin
                    prg_addr = MAP_W'(address[13:0]);
                end
                else
                begin
                    prg_addr = {prg_bank_reg, address[13:0]};
                end
            end
            PRG_MODE_FIX_LAST:
            begin
                if (!address[14])
                begin
                    prg_addr = {prg_bank_reg, address[13:0]};
                end
                else
                begin
                    prg_addr = {last_unit, address[13:0]};
                end
            end
            default:
            begin
                prg_addr = {prg_bank_reg[3:1], address[14:0]};
            end
        endcase
    end

    assign load_value = {write_data[0], shift_bits_reg};

    always_comb
    begin
        units_next       = units_reg;
        chr_ram_next     = chr_ram_reg;
        shift_bits_next  = shift_bits_reg;
        shift_count_next = shift_count_reg;
        control_next     = control_reg;
        chr_low_next     = chr_low_reg;
        chr_high_next    = chr_high_reg;
        prg_bank_next    = prg_bank_reg;
        mirror_next      = mirror_reg;
        result           = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRG_ROM_UNITS:    units_next = cfg_data;
                CFG_CHR_IS_RAM:       chr_ram_next = cfg_data[0];
                CFG_INITIAL_VERTICAL: mirror_next = cfg_data[0];
                default:              ;
            endcase
        end

        if (accept)
        begin
            if (address[15:13] == 3'b000)
            begin
                result.target         = TGT_CHR;
                result.mapped_address = chr_addr;
                result.write_enable   = mode & chr_ram_reg;
            end
            else if (address[15:13] == 3'b011)
            begin
                result.target         = TGT_PRG_RAM;
                result.mapped_address = MAP_W'(address[12:0]);
                result.write_enable   = mode;
            end
            else if (address[15])
            begin
                if (!mode)
                begin
                    result.target         = TGT_PRG_ROM;
                    result.mapped_address = prg_addr;
                end
                else if (write_data[7])
                begin
                    shift_bits_next  = '0;
                    shift_count_next = '0;
                    control_next     = CONTROL_RESET;
                end
                else if (shift_count_reg == SHIFT_LAST)
                begin
                    shift_bits_next  = '0;
                    shift_count_next = '0;
                    case (address[14:13])
                        REG_SEL_CONTROL:
                        begin
                            control_next = load_value;
                            mirror_next  = (load_value[1:0] == MIRROR_VERTICAL_CODE);
                        end
                        REG_SEL_CHR_LOW:  chr_low_next  = load_value;
                        REG_SEL_CHR_HIGH: chr_high_next = load_value;
                        REG_SEL_PRG:      prg_bank_next = load_value[3:0];
                        default:          ;
                    endcase
                end
                else
                begin
                    shift_bits_next[shift_count_reg[1:0]] = write_data[0];
                    shift_count_next = shift_count_reg + 3'd1;
                end
            end
            result.vertical_mirroring = mirror_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg       <= UNITS_RESET;
            chr_ram_reg     <= 1'b0;
            shift_bits_reg  <= '0;
            shift_count_reg <= '0;
            control_reg     <= CONTROL_RESET;
            chr_low_reg     <= '0;
            chr_high_reg    <= '0;
            prg_bank_reg    <= '0;
            mirror_reg      <= 1'b0;
        end
        else
        begin
            units_reg       <= units_next;
            chr_ram_reg     <= chr_ram_next;
            shift_bits_reg  <= shift_bits_next;
            shift_count_reg <= shift_count_next;
            control_reg     <= control_next;
            chr_low_reg     <= chr_low_next;
            chr_high_reg    <= chr_high_next;
            prg_bank_reg    <= prg_bank_next;
            mirror_reg      <= mirror_next;
        end
    end

endmodule

@@ hw/rtl/serial_loaded_bank_mapper.sv @@
// Top level of the serial loaded bank mapper: core plus output skid buffer.
//
//  channel   dir   handshake            payload
//  in        in    in_valid / in_stall  mode, address, write_data
//  out       out   out_valid / out_stall target, mapped_address, write_enable,
//                                       vertical_mirroring
//  cfg       in    cfg_we               cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each result is registered.
// The translation and the serial register update sit between the input
// ports and a result register; a second result register absorbs one stall.
// in_stall rises only once both result registers are full.
// Reset clears all mapper state and empties the result registers.
module serial_loaded_bank_mapper
    import slbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [ADDR_W-1:0]     address,
    input  logic [DATA_W-1:0]     write_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            target,
    output logic [MAP_W-1:0]      mapped_address,
    output logic                  write_enable,
    output logic                  vertical_mirroring
);

    logic    accept;
    logic    out_take;
    result_t core_result;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~skid_valid_reg;
    assign out_take = out_valid_reg & ~out_stall;

    slbm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .mode       (mode),
        .address    (address),
        .write_data (write_data),
        .result     (core_result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_next  = core_result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = core_result;
                out_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid          = out_valid_reg;
    assign target             = out_data_reg.target;
    assign mapped_address     = out_data_reg.mapped_address;
    assign write_enable       = out_data_reg.write_enable;
    assign vertical_mirroring = out_data_reg.vertical_mirroring;

endmodule

@@ hw/rtl/slbm_checker.sv @@
// Port checker for the serial loaded bank mapper, bound to the top level.
module slbm_checker
    import slbm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [1:0]       target,
    input logic [MAP_W-1:0] mapped_address,
    input logic             write_enable
);

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_accept_fills_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> out_valid)
        else $error("accepted item did not reach the output");

    a_none_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && target == TGT_NONE) |-> (!write_enable && mapped_address == '0))
        else $error("unmapped result carries address or strobe");

    a_ram_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && target == TGT_PRG_RAM) |-> (mapped_address[MAP_W-1:13] == '0))
        else $error("program RAM address out of range");

    a_stalled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(mapped_address)))
        else $error("stalled result changed");

endmodule

bind serial_loaded_bank_mapper slbm_checker u_slbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .target         (target),
    .mapped_address (mapped_address),
    .write_enable   (write_enable)
);
